@@ rtl/ncmc_pkg.sv @@
package ncmc_pkg;

	localparam int MAX_CLASSES = 16;
	localparam int EMBED_DIM   = 16;
	localparam int ELEM_BITS   = 16;

	localparam int MAG_W   = ELEM_BITS + 1;
	localparam int CLS_W   = $clog2(MAX_CLASSES);
	localparam int CNT_W   = $clog2(MAX_CLASSES + 1);
	localparam int POS_W   = (EMBED_DIM > 1) ? $clog2(EMBED_DIM) : 1;
	localparam int DEPTH   = MAX_CLASSES * EMBED_DIM;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int DIST_W  = 36;
	localparam int SCNT_W  = 16;
	localparam int CID_W   = 6;
	localparam int DIV_N   = MAG_W;
	localparam int DIVC_W  = $clog2(DIV_N + 1);
	localparam int PROD_W  = 2 * MAG_W;
	localparam int SQ_SHIFT = 18;

	localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
	localparam logic [SCNT_W-1:0] COUNT_MAX = {SCNT_W{1'b1}};

	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_CLASSIFY = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_NOCLASS = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BEGIN,
		S_A_RD,
		S_A_LOAD,
		S_A_DIV,
		S_A_WR,
		S_C_RD,
		S_C_SQ,
		S_C_ACC,
		S_FIN,
		S_FIND,
		S_OUT
	} state_t;

	typedef struct packed {
		logic take;
		logic begin_item;
		logic rd_mean;
		logic div_load;
		logic div_step;
		logic wr_mean;
		logic sq_calc;
		logic acc;
		logic advance;
		logic find_init;
		logic find_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic eff_vop;
		logic eff_cid_ok;
		logic regs_zero;
		logic cls_last;
		logic div_last;
		logic pos_last;
		logic vop;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/ncmc_ctrl.sv @@
module ncmc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ncmc_pkg::sts_t  sts,
	output ncmc_pkg::cmd_t  cmd
);

	ncmc_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ncmc_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ncmc_pkg::S_IDLE: begin
				if (in_valid) state_nx = ncmc_pkg::S_BEGIN;
			end
			ncmc_pkg::S_BEGIN: begin
				priority if (sts.op == ncmc_pkg::OP_NONE) state_nx = ncmc_pkg::S_IDLE;
				else if (sts.op == ncmc_pkg::OP_CLEAR) state_nx = ncmc_pkg::S_OUT;
				else if (!sts.eff_vop) state_nx = sts.eff_cid_ok ? ncmc_pkg::S_A_RD
					: ncmc_pkg::S_FIN;
				else state_nx = sts.regs_zero ? ncmc_pkg::S_FIN : ncmc_pkg::S_C_RD;
			end
			ncmc_pkg::S_A_RD:   state_nx = ncmc_pkg::S_A_LOAD;
			ncmc_pkg::S_A_LOAD: state_nx = ncmc_pkg::S_A_DIV;
			ncmc_pkg::S_A_DIV: begin
				if (sts.div_last) state_nx = ncmc_pkg::S_A_WR;
			end
			ncmc_pkg::S_A_WR:   state_nx = ncmc_pkg::S_FIN;
			ncmc_pkg::S_C_RD:   state_nx = ncmc_pkg::S_C_SQ;
			ncmc_pkg::S_C_SQ:   state_nx = ncmc_pkg::S_C_ACC;
			ncmc_pkg::S_C_ACC:  state_nx = sts.cls_last ? ncmc_pkg::S_FIN : ncmc_pkg::S_C_RD;
			ncmc_pkg::S_FIN: begin
				priority if (!sts.pos_last) state_nx = ncmc_pkg::S_IDLE;
				else if (sts.vop) state_nx = ncmc_pkg::S_FIND;
				else state_nx = ncmc_pkg::S_OUT;
			end
			ncmc_pkg::S_FIND: begin
				if (sts.regs_zero || sts.cls_last) state_nx = ncmc_pkg::S_OUT;
			end
			ncmc_pkg::S_OUT: begin
				if (sts.out_free) state_nx = ncmc_pkg::S_IDLE;
			end
			default: state_nx = ncmc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ncmc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ncmc_pkg::S_BEGIN:  cmd.begin_item = 1'b1;
			ncmc_pkg::S_A_RD:   cmd.rd_mean = 1'b1;
			ncmc_pkg::S_A_LOAD: cmd.div_load = 1'b1;
			ncmc_pkg::S_A_DIV:  cmd.div_step = 1'b1;
			ncmc_pkg::S_A_WR:   cmd.wr_mean = 1'b1;
			ncmc_pkg::S_C_RD:   cmd.rd_mean = 1'b1;
			ncmc_pkg::S_C_SQ:   cmd.sq_calc = 1'b1;
			ncmc_pkg::S_C_ACC:  cmd.acc = 1'b1;
			ncmc_pkg::S_FIN: begin
				cmd.advance = 1'b1;
				cmd.find_init = 1'b1;
			end
			ncmc_pkg::S_FIND:   cmd.find_step = !sts.regs_zero;
			ncmc_pkg::S_OUT:    cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

@@ rtl/ncmc_datapath.sv @@
module ncmc_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [1:0]                   in_op,
	input  logic [ncmc_pkg::CID_W-1:0]   in_cid,
	input  logic [ncmc_pkg::ELEM_BITS-1:0] in_elem,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [1:0]                   out_status,
	output logic [3:0]                   out_best_class,
	output logic [ncmc_pkg::DIST_W-1:0]  out_best_distance,
	output logic [4:0]                   out_class_count,
	input  ncmc_pkg::cmd_t               cmd,
	output ncmc_pkg::sts_t               sts
);

	localparam int EW = ncmc_pkg::ELEM_BITS;
	localparam int MW = ncmc_pkg::MAG_W;
	localparam int CW = ncmc_pkg::CLS_W;
	localparam int NW = ncmc_pkg::CNT_W;
	localparam int PW = ncmc_pkg::POS_W;
	localparam int AW = ncmc_pkg::ADDR_W;
	localparam int DW = ncmc_pkg::DIST_W;
	localparam int SW = ncmc_pkg::SCNT_W;

	// latched item
	ncmc_pkg::op_t                op_q;
	logic [ncmc_pkg::CID_W-1:0]   cid_q;
	logic [EW-1:0]                x_q;

	// vector and class state
	logic [PW-1:0]                pos_q;
	logic                         vop_q;
	logic [ncmc_pkg::CID_W-1:0]   vcid_q;
	logic [NW-1:0]                regs_q;
	logic [SW-1:0]                counts_q [ncmc_pkg::MAX_CLASSES];
	logic [DW-1:0]                dist_q [ncmc_pkg::MAX_CLASSES];
	logic                         valid_q [ncmc_pkg::DEPTH];
	logic [CW-1:0]                cls_q;

	// mean memory
	logic [EW-1:0]                means_mem [ncmc_pkg::DEPTH];
	logic [EW-1:0]                rd_q;
	logic                         rd_valid_q;
	logic [AW-1:0]                addr;
	logic [CW-1:0]                rd_cls;
	logic [EW-1:0]                mean_eff;

	// divider
	logic [MW-1:0]                dvd_q;
	logic [MW-1:0]                quo_q;
	logic [SW-1:0]                rem_q;
	logic [SW-1:0]                divisor_q;
	logic                         neg_q;
	logic [EW-1:0]                m_q;
	logic [ncmc_pkg::DIVC_W-1:0]  dcnt_q;
	logic [SW:0]                  trial;
	logic [SW:0]                  trial_sub;
	logic [MW:0]                  q_signed;
	logic [EW-1:0]                new_mean;

	// distance
	logic signed [MW-1:0]         diff;
	logic [MW-1:0]                mag;
	logic [ncmc_pkg::PROD_W-1:0]  prod;
	logic [DW-1:0]                sq_q;
	logic [DW:0]                  acc_sum;
	logic                         found_q;
	logic [CW-1:0]                best_q;
	logic [DW-1:0]                bestd_q;

	logic                         cid_in_range;
	logic                         vcid_in_range;
	logic [CW-1:0]                cid_idx;

	assign cid_in_range  = cid_q < ncmc_pkg::CID_W'(ncmc_pkg::MAX_CLASSES);
	assign vcid_in_range = vcid_q < ncmc_pkg::CID_W'(ncmc_pkg::MAX_CLASSES);
	assign cid_idx = cid_q[CW-1:0];

	assign rd_cls = vop_q ? cls_q : vcid_q[CW-1:0];
	assign addr = AW'(rd_cls) * AW'(ncmc_pkg::EMBED_DIM) + AW'(pos_q);
	assign mean_eff = rd_valid_q ? rd_q : '0;

	assign diff = MW'($signed(x_q)) - MW'($signed(mean_eff));
	assign mag  = diff[MW-1] ? MW'(-diff) : MW'(diff);
	assign prod = ncmc_pkg::PROD_W'(mag) * ncmc_pkg::PROD_W'(mag);

	assign trial     = {rem_q, dvd_q[MW-1]};
	assign trial_sub = trial - {1'b0, divisor_q};
	assign q_signed  = neg_q ? (MW+1)'(-{1'b0, quo_q}) : {1'b0, quo_q};
	assign new_mean  = EW'((MW+1)'($signed(m_q)) + q_signed);

	assign acc_sum = {1'b0, dist_q[cls_q]} + {1'b0, sq_q};

	always_comb begin
		sts.op         = op_q;
		sts.eff_vop    = (pos_q == '0) ? (op_q == ncmc_pkg::OP_CLASSIFY) : vop_q;
		sts.eff_cid_ok = (pos_q == '0) ? cid_in_range : vcid_in_range;
		sts.regs_zero  = (regs_q == '0);
		sts.cls_last   = (cls_q == CW'(regs_q - NW'(1)));
		sts.div_last   = (dcnt_q == ncmc_pkg::DIVC_W'(1));
		sts.pos_last   = (pos_q == PW'(ncmc_pkg::EMBED_DIM - 1));
		sts.vop        = vop_q;
		sts.out_free   = !out_valid || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_mean) means_mem[addr] <= new_mean;
		if (cmd.rd_mean) rd_q <= means_mem[addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= ncmc_pkg::op_t'(in_op);
			cid_q <= in_cid;
			x_q   <= in_elem;
		end
		if (cmd.div_load) begin
			dvd_q     <= mag;
			quo_q     <= '0;
			rem_q     <= '0;
			divisor_q <= counts_q[vcid_q[CW-1:0]];
			neg_q     <= diff[MW-1];
			m_q       <= mean_eff;
			dcnt_q    <= ncmc_pkg::DIVC_W'(ncmc_pkg::DIV_N);
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[MW-2:0], 1'b0};
			dcnt_q <= dcnt_q - ncmc_pkg::DIVC_W'(1);
			if (!trial_sub[SW]) begin
				rem_q <= trial_sub[SW-1:0];
				quo_q <= {quo_q[MW-2:0], 1'b1};
			end else begin
				rem_q <= trial[SW-1:0];
				quo_q <= {quo_q[MW-2:0], 1'b0};
			end
		end
		if (cmd.sq_calc) begin
			if ((mag >> ncmc_pkg::SQ_SHIFT) != '0) sq_q <= ncmc_pkg::DIST_MAX;
			else sq_q <= DW'(prod);
		end
		if (cmd.find_init) begin
			best_q  <= '0;
			bestd_q <= '0;
		end else if (cmd.find_step) begin
			if (counts_q[cls_q] != '0 && (!found_q || dist_q[cls_q] < bestd_q)) begin
				best_q  <= cls_q;
				bestd_q <= dist_q[cls_q];
			end
		end
		if (cmd.out_load) begin
			out_class_count <= 5'(regs_q);
			if (vop_q) begin
				out_status        <= found_q ? ncmc_pkg::ST_OK : ncmc_pkg::ST_NOCLASS;
				out_best_class    <= found_q ? 4'(best_q) : 4'd0;
				out_best_distance <= found_q ? bestd_q : '0;
			end else begin
				out_status        <= vcid_in_range ? ncmc_pkg::ST_OK : ncmc_pkg::ST_RANGE;
				out_best_class    <= 4'd0;
				out_best_distance <= '0;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			vop_q      <= 1'b0;
			vcid_q     <= '0;
			regs_q     <= '0;
			cls_q      <= '0;
			found_q    <= 1'b0;
			rd_valid_q <= 1'b0;
			out_valid  <= 1'b0;
			for (int i = 0; i < ncmc_pkg::MAX_CLASSES; i++) begin
				counts_q[i] <= '0;
				dist_q[i]   <= '0;
			end
			for (int i = 0; i < ncmc_pkg::DEPTH; i++) valid_q[i] <= 1'b0;
		end else begin
			if (cmd.begin_item) begin
				cls_q <= '0;
				if (op_q == ncmc_pkg::OP_CLEAR) begin
					pos_q  <= '0;
					vop_q  <= 1'b0;
					vcid_q <= '0;
					regs_q <= '0;
					for (int i = 0; i < ncmc_pkg::MAX_CLASSES; i++) begin
						counts_q[i] <= '0;
						dist_q[i]   <= '0;
					end
					for (int i = 0; i < ncmc_pkg::DEPTH; i++) valid_q[i] <= 1'b0;
				end else if (op_q != ncmc_pkg::OP_NONE && pos_q == '0) begin
					vop_q  <= (op_q == ncmc_pkg::OP_CLASSIFY);
					vcid_q <= cid_q;
					if (op_q == ncmc_pkg::OP_ADD) begin
						if (cid_in_range) begin
							if (counts_q[cid_idx] == '0 && NW'(cid_q) >= regs_q)
								regs_q <= NW'(cid_q) + NW'(1);
							if (counts_q[cid_idx] != ncmc_pkg::COUNT_MAX)
								counts_q[cid_idx] <= counts_q[cid_idx] + SW'(1);
						end
					end else begin
						for (int i = 0; i < ncmc_pkg::MAX_CLASSES; i++) dist_q[i] <= '0;
					end
				end
			end
			if (cmd.rd_mean) rd_valid_q <= valid_q[addr];
			if (cmd.wr_mean) valid_q[addr] <= 1'b1;
			if (cmd.acc) begin
				if (counts_q[cls_q] != '0)
					dist_q[cls_q] <= acc_sum[DW] ? ncmc_pkg::DIST_MAX : acc_sum[DW-1:0];
				cls_q <= cls_q + CW'(1);
			end
			if (cmd.advance) pos_q <= sts.pos_last ? '0 : pos_q + PW'(1);
			if (cmd.find_init) begin
				cls_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.find_step) begin
				if (counts_q[cls_q] != '0) found_q <= 1'b1;
				cls_q <= cls_q + CW'(1);
			end
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

endmodule

@@ rtl/nearest_class_mean_classifier_unit.sv @@
// one item at a time: an add element reads its mean, runs a 17-step restoring divide and
// writes the mean back, or skips these when its class is out of range; a classify element
// reads, squares and accumulates once per class below the class count; the last element
// of a vector adds an output step, and a classify one also a minimum search; a clear goes
// to output, an ignored item back to idle; results sit in an output register, so the next
// item is taken while a result waits; arst_n clears counts, sums and mean valid bits at once
module nearest_class_mean_classifier_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // class_id [5:0], element [21:6]
	input  logic [1:0]  s_axis_tuser,  // operation [1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // best_class [3:0], best_distance [39:4], class_count [44:40]
	output logic [1:0]  m_axis_tuser   // status [1:0]
);

	ncmc_pkg::cmd_t cmd;
	ncmc_pkg::sts_t sts;
	logic [3:0]                  best_class;
	logic [ncmc_pkg::DIST_W-1:0] best_distance;
	logic [4:0]                  class_count;

	ncmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ncmc_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_op             (s_axis_tuser),
		.in_cid            (s_axis_tdata[5:0]),
		.in_elem           (s_axis_tdata[21:6]),
		.out_ready         (m_axis_tready),
		.out_valid         (m_axis_tvalid),
		.out_status        (m_axis_tuser),
		.out_best_class    (best_class),
		.out_best_distance (best_distance),
		.out_class_count   (class_count),
		.cmd               (cmd),
		.sts               (sts)
	);

	assign m_axis_tdata = {3'b000, class_count, best_distance, best_class};

endmodule

@@ rtl/ncmc_checker.sv @@
module ncmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// errors carry no class and no distance
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != 2'd0 |-> m_axis_tdata[39:0] == 40'd0)
		else $error("error result with nonzero class or distance");

	// best class lies below the registered class count
	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == 2'd0 && m_axis_tdata[44:40] != 5'd0
			|-> m_axis_tdata[3:0] < m_axis_tdata[44:40])
		else $error("best class beyond class count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[44:40] <= 5'd16 && m_axis_tdata[47:45] == 3'd0
			&& m_axis_tuser != 2'd3)
		else $error("class count or status out of range");

endmodule

bind nearest_class_mean_classifier_unit ncmc_checker u_ncmc_checker (.*);
